[hw/rtl/pwl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_pkg: shared types and constants for the piecewise-linear lookup
// Table geometry, field widths, command and status codes, and the structs
// that travel between the front, the command queue, the back and the divider.
// ----------------------------------------------------------------------------
package pwl_pkg;

  // Table geometry
  localparam int ROWS   = 256;
  localparam int TABLES = 4;

  // Field widths at the ports
  localparam int CODE_W  = 12;
  localparam int VAL_W   = 24;
  localparam int ROWIN_W = 8;
  localparam int TIDIN_W = 2;
  localparam int STAT_W  = 2;

  localparam int IN_DATA_W  = ((ROWIN_W + CODE_W + VAL_W + 7) / 8) * 8;
  localparam int IN_USER_W  = 1 + TIDIN_W;
  localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_USER_W = STAT_W;

  // Derived internal widths
  localparam int ROW_W   = $clog2(ROWS);
  localparam int TID_W   = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int DEPTH   = TABLES * ROWS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(ROWS + 1);
  localparam int WORD_W  = CODE_W + VAL_W;
  localparam int PROD_W  = VAL_W + CODE_W + 2;
  localparam int DVD_W   = VAL_W + CODE_W;
  localparam int DCNT_W  = $clog2(DVD_W + 1);
  localparam int SUM_W   = DVD_W + 2;

  // Command queue depth, a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_SKIP,
    CMD_CONV
  } cmd_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INTERP   = 2'd0,
    ST_CLAMP    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_WRITE    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [TID_W-1:0]   tid;
    logic [ROW_W-1:0]   row;
    logic [CODE_W-1:0]  code;
    logic [VAL_W-1:0]   tval;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [CODE_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quotient;
  } div_rsp_t;

  // First memory address of a table
  function automatic logic [ADDR_W-1:0] base_of(input logic [TID_W-1:0] tid);
    return ADDR_W'(int'(tid) * ROWS);
  endfunction

endpackage

[hw/rtl/piecewise_linear_lut_interp_top.sv]
`timescale 1ns / 1ps
// Path from input transfer to m_tvalid, back idle: a write passes the input stage,
// the queue and the output register; a conversion scans rows from row 0 and clamps
// at row 0, finds no match, or multiplies and runs the 36-step divide to interpolate.
// Flow: the back handles one item at a time and takes the next only once the output
// register is empty; an input stage and a 4-entry queue keep taking items meanwhile.
// Reset: synchronous; a clearing pass then zeroes the tables, s_tready low.
// ----------------------------------------------------------------------------
// piecewise_linear_lut_interp_top: piecewise-linear calibration lookup
// Four (code, value) calibration tables with descending codes; write items
// store a row, convert items interpolate a sample between bracketing rows.
// ----------------------------------------------------------------------------
module piecewise_linear_lut_interp_top (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: row [7:0], code_value [19:8], table_value [43:20], zero [47:44]
  input  logic [pwl_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: mode [0], table_id [2:1]
  input  logic [pwl_pkg::IN_USER_W-1:0]    s_tuser,
  // Result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: value [23:0]
  output logic [pwl_pkg::OUT_DATA_W-1:0]   m_tdata,
  // m_tuser: status [1:0]
  output logic [pwl_pkg::OUT_USER_W-1:0]   m_tuser
);

  logic               clearing;
  logic               push_valid;
  pwl_pkg::cmd_t      push_cmd;
  logic               fifo_full;
  logic               pop;
  logic               pop_valid;
  pwl_pkg::cmd_t      pop_cmd;
  pwl_pkg::div_req_t  div_req;
  pwl_pkg::div_rsp_t  div_rsp;

  // Front: decode each input transfer, fold bad table ids onto table 0,
  // mark writes past the last row so the back answers without storing.
  pwl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .hold       (clearing),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (fifo_full)
  );

  // Queue: lets the front keep taking items while the back scans or divides
  pwl_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd)
  );

  // Back: table memory, clearing sweep, scan, interpolation, output register
  pwl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  // Serial divider for the interpolation quotient
  pwl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

`ifndef SYNTHESIS
  // No transfer may be taken while the tables are being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted during clearing pass");

  // Leaving reset always starts the clearing pass
  a_reset_starts_clear: assert property (@(posedge clk)
    $fell(rst) |-> clearing)
    else $error("clearing pass not running after reset");

  // Write and not-found results carry a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == pwl_pkg::ST_NOTFOUND || m_tuser == pwl_pkg::ST_WRITE)
    |-> (m_tdata == '0))
    else $error("nonzero value on write or not-found result");
`endif

endmodule

[hw/rtl/pwl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_front: input stage
// Accepts input transfers, decodes and classifies them into commands and
// hands them to the command queue through one register stage.
// ----------------------------------------------------------------------------
module pwl_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pwl_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [pwl_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                            hold,
  output logic                            push_valid,
  output pwl_pkg::cmd_t                   push_cmd,
  input  logic                            full
);

  logic                          mode;
  logic [pwl_pkg::TIDIN_W-1:0]   tid_in;
  logic [pwl_pkg::ROWIN_W-1:0]   row_in;
  pwl_pkg::cmd_t                 cmd_next;
  logic                          stg_valid;
  pwl_pkg::cmd_t                 stg_cmd;

  always_comb begin
    mode   = s_tuser[0];
    tid_in = s_tuser[1 +: pwl_pkg::TIDIN_W];
    row_in = s_tdata[pwl_pkg::ROWIN_W-1:0];

    cmd_next.code = s_tdata[pwl_pkg::ROWIN_W +: pwl_pkg::CODE_W];
    cmd_next.tval = s_tdata[pwl_pkg::ROWIN_W + pwl_pkg::CODE_W +: pwl_pkg::VAL_W];
    cmd_next.row  = pwl_pkg::ROW_W'(row_in);

    // Unknown table falls back to table 0
    if (int'(tid_in) < pwl_pkg::TABLES) begin
      cmd_next.tid = pwl_pkg::TID_W'(tid_in);
    end else begin
      cmd_next.tid = '0;
    end

    if (mode) begin
      cmd_next.kind = pwl_pkg::CMD_CONV;
    end else if (int'(row_in) < pwl_pkg::ROWS) begin
      cmd_next.kind = pwl_pkg::CMD_WRITE;
    end else begin
      cmd_next.kind = pwl_pkg::CMD_SKIP;
    end
  end

  assign s_tready   = !hold && (!stg_valid || !full);
  assign push_valid = stg_valid;
  assign push_cmd   = stg_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stg_valid <= 1'b1;
    end else if (!full) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stg_cmd <= cmd_next;
    end
  end

endmodule

[hw/rtl/pwl_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_fifo: command queue
// Short queue of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
module pwl_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  pwl_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output pwl_pkg::cmd_t  pop_cmd
);

  pwl_pkg::cmd_t                   entries [pwl_pkg::FIFO_DEPTH];
  logic [pwl_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [pwl_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [pwl_pkg::FIFO_PTR_W:0]    count;
  logic                            do_push;
  logic                            do_pop;

  assign full      = (count == (pwl_pkg::FIFO_PTR_W + 1)'(pwl_pkg::FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hw/rtl/pwl_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulses with the result.
// ----------------------------------------------------------------------------
module pwl_div (
  input  logic               clk,
  input  logic               rst,
  input  pwl_pkg::div_req_t  req,
  output pwl_pkg::div_rsp_t  rsp
);

  logic                          busy;
  logic                          done;
  logic [pwl_pkg::DCNT_W-1:0]    cnt;
  logic [pwl_pkg::CODE_W-1:0]    rem;
  logic [pwl_pkg::CODE_W-1:0]    dsr;
  logic [pwl_pkg::DVD_W-1:0]     quo;
  logic [pwl_pkg::CODE_W:0]      trial;
  logic                          fits;

  assign trial = {rem, quo[pwl_pkg::DVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= pwl_pkg::DCNT_W'(pwl_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pwl_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= pwl_pkg::CODE_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[pwl_pkg::CODE_W-1:0];
      end
      quo <= {quo[pwl_pkg::DVD_W-2:0], fits};
    end
  end

endmodule

[hw/rtl/pwl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_back: table store and conversion engine
// Owns the table memory, clears it after reset, stores rows, scans a table
// for the bracketing rows, interpolates and holds the output register.
// ----------------------------------------------------------------------------
module pwl_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pop_valid,
  input  pwl_pkg::cmd_t                    pop_cmd,
  output logic                             pop,
  output logic                             clearing,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pwl_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [pwl_pkg::OUT_USER_W-1:0]   m_tuser,
  output pwl_pkg::div_req_t                div_req,
  input  pwl_pkg::div_rsp_t                div_rsp
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DSTART,
    S_DWAIT
  } state_t;

  state_t                            state;

  // Table memory, one word per row: code above value
  logic [pwl_pkg::WORD_W-1:0]        mem [pwl_pkg::DEPTH];
  logic [pwl_pkg::WORD_W-1:0]        rd_q;
  logic [pwl_pkg::ADDR_W-1:0]        rd_addr;
  logic                              we;
  logic [pwl_pkg::ADDR_W-1:0]        wa;
  logic [pwl_pkg::WORD_W-1:0]        wd;

  logic [pwl_pkg::ADDR_W-1:0]        clr_addr;
  logic [pwl_pkg::ADDR_W-1:0]        base_r;
  logic [pwl_pkg::CODE_W-1:0]        sample;
  logic [pwl_pkg::CNT_W-1:0]         ridx;
  logic                              rd_dv;
  logic [pwl_pkg::ROW_W-1:0]         didx;
  logic                              issue;
  logic [pwl_pkg::CODE_W-1:0]        rd_code;
  logic [pwl_pkg::VAL_W-1:0]         rd_val;
  logic [pwl_pkg::CODE_W-1:0]        prev_code;
  logic [pwl_pkg::VAL_W-1:0]         prev_val;
  logic [pwl_pkg::CODE_W-1:0]        x1;
  logic [pwl_pkg::VAL_W-1:0]         y1;

  logic signed [pwl_pkg::VAL_W:0]    dy;
  logic [pwl_pkg::CODE_W-1:0]        dx;
  logic signed [pwl_pkg::PROD_W-1:0] prod_next;
  logic signed [pwl_pkg::PROD_W-1:0] prod;
  logic signed [pwl_pkg::PROD_W-1:0] prod_abs;
  logic [pwl_pkg::CODE_W-1:0]        span;

  logic signed [pwl_pkg::SUM_W-1:0]  q_ext;
  logic signed [pwl_pkg::SUM_W-1:0]  sum;
  logic signed [pwl_pkg::SUM_W-1:0]  sat_hi;
  logic signed [pwl_pkg::SUM_W-1:0]  sat_lo;
  logic [pwl_pkg::VAL_W-1:0]         sat_val;

  logic                              o_valid;
  logic [pwl_pkg::VAL_W-1:0]         o_value;
  pwl_pkg::status_t                  o_status;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !o_valid && pop_valid;
  assign issue    = (state == S_SCAN) && (ridx < pwl_pkg::CNT_W'(pwl_pkg::ROWS));
  assign rd_addr  = base_r + pwl_pkg::ADDR_W'(ridx[pwl_pkg::ROW_W-1:0]);
  assign rd_code  = rd_q[pwl_pkg::WORD_W-1 -: pwl_pkg::CODE_W];
  assign rd_val   = rd_q[pwl_pkg::VAL_W-1:0];

  // Memory write port: clearing sweep or a row write
  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (pop && (pop_cmd.kind == pwl_pkg::CMD_WRITE)) begin
      we = 1'b1;
      wa = pwl_pkg::base_of(pop_cmd.tid) + pwl_pkg::ADDR_W'(pop_cmd.row);
      wd = {pop_cmd.code, pop_cmd.tval};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  // Interpolation arithmetic
  always_comb begin
    dy        = $signed({y1[pwl_pkg::VAL_W-1], y1})
              - $signed({prev_val[pwl_pkg::VAL_W-1], prev_val});
    dx        = sample - x1;
    prod_next = dy * $signed({1'b0, dx});
    prod_abs  = prod[pwl_pkg::PROD_W-1] ? -prod : prod;

    div_req.start    = (state == S_DSTART);
    div_req.dividend = prod_abs[pwl_pkg::DVD_W-1:0];
    div_req.divisor  = span;

    // Quotient toward zero, sign flipped because the span runs downward
    q_ext  = $signed({2'b00, div_rsp.quotient});
    sum    = $signed({{(pwl_pkg::SUM_W - pwl_pkg::VAL_W){y1[pwl_pkg::VAL_W-1]}}, y1})
           + (prod[pwl_pkg::PROD_W-1] ? q_ext : -q_ext);
    sat_hi = $signed({{(pwl_pkg::SUM_W - pwl_pkg::VAL_W + 1){1'b0}},
                      {(pwl_pkg::VAL_W - 1){1'b1}}});
    sat_lo = $signed({{(pwl_pkg::SUM_W - pwl_pkg::VAL_W + 1){1'b1}},
                      {(pwl_pkg::VAL_W - 1){1'b0}}});
    if (sum > sat_hi) begin
      sat_val = sat_hi[pwl_pkg::VAL_W-1:0];
    end else if (sum < sat_lo) begin
      sat_val = sat_lo[pwl_pkg::VAL_W-1:0];
    end else begin
      sat_val = sum[pwl_pkg::VAL_W-1:0];
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = pwl_pkg::OUT_DATA_W'(o_value);
  assign m_tuser  = o_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      o_valid  <= 1'b0;
      rd_dv    <= 1'b0;
    end else begin
      if (o_valid && m_tready) begin
        o_valid <= 1'b0;
      end
      rd_dv <= issue;
      didx  <= ridx[pwl_pkg::ROW_W-1:0];
      if (issue) begin
        ridx <= ridx + 1'b1;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == pwl_pkg::ADDR_W'(pwl_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (pop) begin
            unique case (pop_cmd.kind)
              pwl_pkg::CMD_CONV: begin
                base_r <= pwl_pkg::base_of(pop_cmd.tid);
                sample <= pop_cmd.code;
                ridx   <= '0;
                state  <= S_SCAN;
              end
              default: begin
                o_valid  <= 1'b1;
                o_value  <= '0;
                o_status <= pwl_pkg::ST_WRITE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (rd_dv) begin
            if (rd_code < sample) begin
              if (didx == '0) begin
                o_valid  <= 1'b1;
                o_value  <= rd_val;
                o_status <= pwl_pkg::ST_CLAMP;
                state    <= S_IDLE;
              end else begin
                x1    <= rd_code;
                y1    <= rd_val;
                state <= S_MUL;
              end
            end else if (didx == pwl_pkg::ROW_W'(pwl_pkg::ROWS - 1)) begin
              o_valid  <= 1'b1;
              o_value  <= '0;
              o_status <= pwl_pkg::ST_NOTFOUND;
              state    <= S_IDLE;
            end else begin
              prev_code <= rd_code;
              prev_val  <= rd_val;
            end
          end
        end

        S_MUL: begin
          prod  <= prod_next;
          span  <= prev_code - x1;
          state <= S_DSTART;
        end

        S_DSTART: begin
          state <= S_DWAIT;
        end

        S_DWAIT: begin
          if (div_rsp.done) begin
            o_valid  <= 1'b1;
            o_value  <= sat_val;
            o_status <= pwl_pkg::ST_INTERP;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/pwl_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_tb_pkg: verification codes for the piecewise-linear lookup
// Item modes shared by the stimulus and the result checker.
// ----------------------------------------------------------------------------
package pwl_tb_pkg;

  typedef enum logic {
    MODE_WRITE   = 1'b0,
    MODE_CONVERT = 1'b1
  } mode_t;

endpackage

[verif/pwl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_checker: result checker for the piecewise-linear lookup
// Mirrors the calibration tables from the input transfers, computes each
// expected result and compares it with the result stream in order.
// ----------------------------------------------------------------------------
module pwl_checker
  import pwl_pkg::*;
  import pwl_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [OUT_USER_W-1:0] m_tuser,
  output int                    errors,
  output int                    outstanding
);

  localparam longint VAL_HI = (longint'(1) << (VAL_W - 1)) - 1;
  localparam longint VAL_LO = -(longint'(1) << (VAL_W - 1));

  typedef struct {
    logic [VAL_W-1:0] value;
    status_t          status;
    int               seq;
  } calib_result_t;

  calib_result_t     awaited_results[$];
  logic [CODE_W-1:0] code_tbl[DEPTH];
  logic [VAL_W-1:0]  val_tbl[DEPTH];
  int                accepted;

  // Apply one item to the mirrored tables and return what the block must answer
  function automatic calib_result_t calib_lookup(input mode_t                mode,
                                                 input logic [TIDIN_W-1:0] tid,
                                                 input logic [ROWIN_W-1:0] row,
                                                 input logic [CODE_W-1:0]  sample,
                                                 input logic [VAL_W-1:0]   tval);
    calib_result_t r;
    int            base;
    int            hit;
    longint        x0, x1, y0, y1, num, sum;
    r.value = '0;
    r.seq   = accepted;
    base    = ((int'(tid) < TABLES) ? int'(tid) : 0) * ROWS;
    if (mode == MODE_WRITE) begin
      if (int'(row) < ROWS) begin
        code_tbl[base + int'(row)] = sample;
        val_tbl[base + int'(row)]  = tval;
      end
      r.status = ST_WRITE;
      return r;
    end
    // first row whose code lies strictly below the sample
    hit = ROWS;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (code_tbl[base + i] < sample) hit = i;
    end
    if (hit == ROWS) begin
      r.status = ST_NOTFOUND;
    end else if (hit == 0) begin
      r.status = ST_CLAMP;
      r.value  = val_tbl[base];
    end else begin
      x1  = longint'(code_tbl[base + hit]);
      x0  = longint'(code_tbl[base + hit - 1]);
      y1  = longint'(signed'(val_tbl[base + hit]));
      y0  = longint'(signed'(val_tbl[base + hit - 1]));
      num = (y1 - y0) * (longint'(sample) - x1);
      sum = y1 - num / (x0 - x1);
      if (sum > VAL_HI) sum = VAL_HI;
      if (sum < VAL_LO) sum = VAL_LO;
      r.value  = sum[VAL_W-1:0];
      r.status = ST_INTERP;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    calib_result_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        code_tbl[i] = '0;
        val_tbl[i]  = '0;
      end
      awaited_results.delete();
      accepted = 0;
    end else begin
      // retire the oldest expectation before adding one from this edge
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %h status %0d", $time,
                   m_tdata[VAL_W-1:0], m_tuser);
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata[VAL_W-1:0] !== want.value) begin
            errors++;
            $display("%0t: item %0d value expected %h actual %h", $time,
                     want.seq, want.value, m_tdata[VAL_W-1:0]);
          end
          if (m_tuser !== want.status) begin
            errors++;
            $display("%0t: item %0d status expected %0d actual %0d", $time,
                     want.seq, want.status, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(calib_lookup(mode_t'(s_tuser[0]),
                                               s_tuser[TIDIN_W:1],
                                               s_tdata[ROWIN_W-1:0],
                                               s_tdata[ROWIN_W +: CODE_W],
                                               s_tdata[ROWIN_W + CODE_W +: VAL_W]));
        accepted++;
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

[verif/tb_piecewise_linear_lut_interp_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_lut_interp_top: testbench for the calibration lookup
// Drives row writes and conversions into the block, with random gaps on both
// streams, a long result back-pressure stretch and a full drain, and lets
// the checker judge every result.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_lut_interp_top;
  import pwl_pkg::*;
  import pwl_tb_pkg::*;

  localparam int ITEM_TARGET = 750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  int errors;
  int outstanding;
  int items_sent = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  piecewise_linear_lut_interp_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  pwl_checker i_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Offer one item, after an occasional gap, and hold it until the transfer.
  // Items 250..399 go out back to back with no gaps.
  task automatic send_item(input mode_t                mode,
                           input logic [TIDIN_W-1:0] tid,
                           input logic [ROWIN_W-1:0] row,
                           input logic [CODE_W-1:0]  code,
                           input logic [VAL_W-1:0]   tval);
    int gap;
    gap = 0;
    if (!(items_sent >= 250 && items_sent < 400) && $urandom_range(0, 99) < 10)
      gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({tval, code, row});
    s_tuser  <= {tid, mode};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Result side: random stalls, one long hold-off after 150 results, and a
  // stall-free stretch between results 250 and 400
  initial begin : result_sink
    int  taken;
    bit  held;
    taken = 0;
    held  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && taken >= 150) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (taken >= 250 && taken < 400)
        m_tready <= 1'b1;
      else
        m_tready <= ($urandom_range(0, 99) >= 10);
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) taken++;
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [TIDIN_W-1:0] tid;
    logic [CODE_W-1:0]  code;
    int                 nrows;
    int                 step;
    bit                 drained;
    drained = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty tables: sample 0 finds nothing, any larger sample clamps at row 0
    send_item(MODE_CONVERT, 2'd0, 8'd0, 12'd0, '0);
    send_item(MODE_CONVERT, 2'd0, 8'hFF, 12'hFFF, VAL_MAX);

    // Table 1: descending codes with full-scale values
    send_item(MODE_WRITE, 2'd1, 8'd0, 12'd4000, VAL_MAX);
    send_item(MODE_WRITE, 2'd1, 8'd1, 12'd3000, VAL_MIN);
    send_item(MODE_WRITE, 2'd1, 8'd2, 12'd1500, 24'd16);
    send_item(MODE_WRITE, 2'd1, 8'd3, 12'd1, -24'sd16);
    send_item(MODE_CONVERT, 2'd1, 8'd0, 12'hFFF, '0);   // clamp at first row
    send_item(MODE_CONVERT, 2'd1, 8'd0, 12'd4000, '0);  // sample on the upper knot
    send_item(MODE_CONVERT, 2'd1, 8'd0, 12'd3001, '0);  // steep negative slope
    send_item(MODE_CONVERT, 2'd1, 8'd0, 12'd2000, '0);
    send_item(MODE_CONVERT, 2'd1, 8'd0, 12'd2, '0);
    send_item(MODE_CONVERT, 2'd1, 8'd0, 12'd1, '0);     // toward a cleared row
    send_item(MODE_CONVERT, 2'd1, 8'd0, 12'd0, '0);     // no match

    // Table 3: last row written, full scan on a miss
    send_item(MODE_WRITE, 2'd3, 8'd0, 12'd2048, 24'h555555);
    send_item(MODE_WRITE, 2'd3, 8'd255, 12'd0, 24'hAAAAAA);
    send_item(MODE_CONVERT, 2'd3, 8'd0, 12'hFFF, '0);
    send_item(MODE_CONVERT, 2'd3, 8'd0, 12'd100, '0);
    send_item(MODE_CONVERT, 2'd3, 8'd0, 12'd0, '0);

    // Table 2: repeated codes; the strict compare still keeps the span nonzero
    send_item(MODE_WRITE, 2'd2, 8'd0, 12'd500, 24'd100);
    send_item(MODE_WRITE, 2'd2, 8'd1, 12'd500, 24'd200);
    send_item(MODE_WRITE, 2'd2, 8'd2, 12'd400, 24'd300);
    send_item(MODE_WRITE, 2'd2, 8'd7, 12'hFFF, '0);
    send_item(MODE_CONVERT, 2'd2, 8'd0, 12'd500, '0);
    send_item(MODE_CONVERT, 2'd2, 8'd0, 12'd450, '0);

    // Random part: mostly rebuilt tables with conversions, some raw noise
    while (items_sent < ITEM_TARGET) begin
      if (!drained && items_sent >= 400) begin
        wait_drained();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        tid   = TIDIN_W'($urandom());
        nrows = $urandom_range(2, 12);
        code  = CODE_W'($urandom_range(3000, 4095));
        for (int r = 0; r < nrows; r++) begin
          send_item(MODE_WRITE, tid, ROWIN_W'(r), code, VAL_W'($urandom()));
          step = $urandom_range(0, 600);
          code = (int'(code) > step) ? CODE_W'(int'(code) - step) : '0;
        end
        repeat ($urandom_range(3, 8)) begin
          send_item(MODE_CONVERT, tid, ROWIN_W'($urandom()),
                    ($urandom_range(0, 19) == 0) ? '0 : CODE_W'($urandom()),
                    VAL_W'($urandom()));
        end
      end else begin
        send_item(mode_t'($urandom_range(0, 1)), TIDIN_W'($urandom()),
                  ROWIN_W'($urandom()), CODE_W'($urandom()), VAL_W'($urandom()));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pwl_pkg.sv
hw/rtl/pwl_front.sv
hw/rtl/pwl_fifo.sv
hw/rtl/pwl_div.sv
hw/rtl/pwl_back.sv
hw/rtl/piecewise_linear_lut_interp_top.sv
verif/pwl_tb_pkg.sv
verif/pwl_checker.sv
verif/tb_piecewise_linear_lut_interp_top.sv
